FILE: rtl/kpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kpc_pkg
// Key codes, event codes and state types shared by the keypad calculator.
// ----------------------------------------------------------------------------
package kpc_pkg;

    localparam int KPC_OPERAND_BITS = 32;

    localparam logic [7:0] KEY_CLEAR  = 8'h2A;  // '*'
    localparam logic [7:0] KEY_EQUALS = 8'h23;  // '#'
    localparam logic [7:0] KEY_ZERO   = 8'h30;
    localparam logic [7:0] KEY_NINE   = 8'h39;
    localparam logic [7:0] KEY_OP_A   = 8'h41;
    localparam logic [7:0] KEY_OP_D   = 8'h44;

    localparam logic [7:0] SYM_DIV = 8'h2F;
    localparam logic [7:0] SYM_MUL = 8'h2A;
    localparam logic [7:0] SYM_SUB = 8'h2D;
    localparam logic [7:0] SYM_ADD = 8'h2B;

    typedef enum logic [2:0] {
        EV_IGNORED  = 3'd0,
        EV_CLEARED  = 3'd1,
        EV_DIGIT    = 3'd2,
        EV_OPERATOR = 3'd3,
        EV_INTEGER  = 3'd4,
        EV_QUOTIENT = 3'd5,
        EV_DIVZERO  = 3'd6
    } event_kind_t;

    typedef enum logic [1:0] {
        OP_DIV = 2'd0,
        OP_MUL = 2'd1,
        OP_SUB = 2'd2,
        OP_ADD = 2'd3
    } operation_t;

    typedef enum logic [1:0] {
        PH_NONE   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2,
        PH_LOCKED = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FRAC,
        ST_FINISH,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

FILE: rtl/keypad_four_function_calculator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_four_function_calculator
// Four-function keypad calculator with bit-serial multiply and divide.
// ----------------------------------------------------------------------------
// Usage: one ASCII key code enters on s_key_code per s_valid/s_ready transfer
// and exactly one event leaves on the m_ channel for each key.
// Digits, operators, clear, ignored keys and '#' without a loop pass through
// ST_OUT into the m_valid register. '#' with multiply runs a shift-and-add
// loop over the OPERAND_BITS multiplier bits; '#' with divide by a nonzero
// divisor runs a restoring divider over the dividend bits followed by a loop
// for the two hundredths digits (ten steps per digit: load 10*r, then up to
// nine subtractions). Both loops then pass through ST_FINISH and ST_OUT.
// One key is worked at a time: s_ready is high only when no key is in work
// and no event is waiting, so the next key can transfer in the cycle after
// the event transfer. While m_ready is low the event is held in the output
// register and no new key is taken.
// Reset (aresetn low, synchronous) returns to first-operand entry with both
// operands and the operation cleared and drops any pending event.
// ----------------------------------------------------------------------------
module keypad_four_function_calculator
    import kpc_pkg::*;
#(
    parameter int OPERAND_BITS = KPC_OPERAND_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_key_code,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_event_kind,
    output logic [7:0]       m_echo_char,
    output logic signed [31:0] m_result_value,
    output logic [6:0]       m_hundredths
);

    localparam int W  = OPERAND_BITS;
    localparam int CW = $clog2(W + 1);

    state_t     state_reg, state_next;
    phase_t     phase_reg;
    operation_t op_reg;
    logic [W-1:0] a_reg, b_reg;
    logic [W-1:0] acc_reg;     // product / remainder
    logic [W-1:0] sh_reg;      // multiplier bits / dividend bits / quotient
    logic [W-1:0] dv_reg;      // multiplicand / divisor magnitude
    logic [6:0]   hund_reg;
    logic         neg_reg;
    logic [CW-1:0] cnt_reg;
    logic [4:0]   fcnt_reg;

    logic [2:0]  ev_reg;
    logic [7:0]  echo_reg;
    logic [31:0] val_reg;
    logic        out_valid_reg;

    wire accept = s_valid && s_ready;
    wire is_digit = (s_key_code >= KEY_ZERO) && (s_key_code <= KEY_NINE);
    wire is_op    = (s_key_code >= KEY_OP_A) && (s_key_code <= KEY_OP_D);
    wire [3:0] dval = 4'(s_key_code - KEY_ZERO);
    wire operation_t key_op = operation_t'(2'(s_key_code - KEY_OP_A));

    assign s_ready = (state_reg == ST_IDLE) && !out_valid_reg;

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        mag = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [31:0] to_res(input logic [W-1:0] v);
        logic [63:0] e;
        e = 64'(signed'(v));
        to_res = e[31:0];
    endfunction

    // restoring divide step
    logic [W:0] div_trial;
    logic [W:0] div_rem;
    assign div_rem   = {acc_reg, sh_reg[W-1]};
    assign div_trial = div_rem - {1'b0, dv_reg};

    // hundredths digit: load 10*r, then subtract d while it fits, one per cycle
    logic [W+3:0] ten_r;
    logic [W+3:0] ext_reg;
    logic [3:0]   wide_dig_reg;
    logic         frac_load, frac_last, last_sub;
    logic [3:0]   dig_out;
    logic [W+3:0] fr_after;
    assign ten_r     = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1);
    assign frac_load = (fcnt_reg == 5'd0) || (fcnt_reg == 5'd10);
    assign frac_last = (fcnt_reg == 5'd9) || (fcnt_reg == 5'd19);
    // last step of a digit: include this cycle's subtraction
    assign last_sub  = ext_reg >= {4'b0, dv_reg};
    assign dig_out   = wide_dig_reg + {3'b0, last_sub};
    assign fr_after  = last_sub ? ext_reg - {4'b0, dv_reg} : ext_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_key_code == KEY_EQUALS && phase_reg == PH_SECOND) begin
                    if (op_reg == OP_MUL) state_next = ST_MUL;
                    else if (op_reg == OP_DIV && b_reg != '0) state_next = ST_DIV;
                    else state_next = ST_OUT;
                end else if (accept) begin
                    state_next = ST_OUT;
                end
            end
            ST_MUL:    if (cnt_reg == CW'(W - 1)) state_next = ST_FINISH;
            ST_DIV:    if (cnt_reg == CW'(W - 1)) state_next = ST_FRAC;
            ST_FRAC:   if (fcnt_reg == 5'd19) state_next = ST_FINISH;
            ST_FINISH: state_next = ST_OUT;
            ST_OUT:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_FIRST;
            op_reg        <= OP_DIV;
            a_reg         <= '0;
            b_reg         <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            fcnt_reg      <= '0;
        end else begin
            if (m_valid && m_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: if (accept) begin
                    ev_reg   <= EV_IGNORED;
                    echo_reg <= '0;
                    val_reg  <= '0;
                    hund_reg <= '0;
                    cnt_reg  <= '0;
                    fcnt_reg <= '0;
                    if (s_key_code == KEY_CLEAR) begin
                        a_reg <= '0; b_reg <= '0; op_reg <= OP_DIV;
                        phase_reg <= PH_FIRST;
                        ev_reg <= EV_CLEARED;
                    end else if (is_digit && phase_reg != PH_LOCKED) begin
                        ev_reg   <= EV_DIGIT;
                        echo_reg <= s_key_code;
                        if (phase_reg == PH_FIRST)
                            a_reg <= (a_reg << 3) + (a_reg << 1) + W'(dval);
                        else if (phase_reg == PH_SECOND)
                            b_reg <= (b_reg << 3) + (b_reg << 1) + W'(dval);
                    end else if (is_op && phase_reg == PH_FIRST) begin
                        op_reg    <= key_op;
                        phase_reg <= PH_SECOND;
                        ev_reg    <= EV_OPERATOR;
                        case (key_op)
                            OP_DIV:  echo_reg <= SYM_DIV;
                            OP_MUL:  echo_reg <= SYM_MUL;
                            OP_SUB:  echo_reg <= SYM_SUB;
                            default: echo_reg <= SYM_ADD;
                        endcase
                    end else if (s_key_code == KEY_EQUALS && phase_reg == PH_SECOND) begin
                        phase_reg <= PH_LOCKED;
                        unique case (op_reg)
                            OP_ADD: begin
                                ev_reg <= EV_INTEGER; val_reg <= to_res(a_reg + b_reg);
                            end
                            OP_SUB: begin
                                ev_reg <= EV_INTEGER; val_reg <= to_res(a_reg - b_reg);
                            end
                            OP_MUL: begin
                                ev_reg  <= EV_INTEGER;
                                acc_reg <= '0;
                                sh_reg  <= b_reg;
                                dv_reg  <= a_reg;
                            end
                            default: begin
                                if (b_reg == '0) begin
                                    ev_reg <= EV_DIVZERO;
                                end else begin
                                    ev_reg  <= EV_QUOTIENT;
                                    acc_reg <= '0;
                                    sh_reg  <= mag(a_reg);
                                    dv_reg  <= mag(b_reg);
                                    neg_reg <= a_reg[W-1] ^ b_reg[W-1];
                                end
                            end
                        endcase
                    end
                end
                ST_MUL: begin
                    // shift-and-add, product kept modulo 2^W
                    acc_reg <= (acc_reg << 1) + (sh_reg[W-1] ? dv_reg : '0);
                    sh_reg  <= sh_reg << 1;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ST_DIV: begin
                    if (!div_trial[W]) begin
                        acc_reg <= div_trial[W-1:0];
                        sh_reg  <= {sh_reg[W-2:0], 1'b1};
                    end else begin
                        acc_reg <= div_rem[W-1:0];
                        sh_reg  <= {sh_reg[W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ST_FRAC: begin
                    // step 0 of each digit loads 10*r; later steps subtract d
                    fcnt_reg <= fcnt_reg + 1'b1;
                    if (frac_load) begin
                        ext_reg      <= ten_r;
                        wide_dig_reg <= '0;
                    end else if (last_sub) begin
                        ext_reg      <= ext_reg - {4'b0, dv_reg};
                        wide_dig_reg <= wide_dig_reg + 1'b1;
                    end
                    if (frac_last) begin
                        hund_reg <= 7'((hund_reg << 3) + (hund_reg << 1)) + 7'(dig_out);
                        acc_reg  <= fr_after[W-1:0];
                    end
                end
                ST_FINISH: begin
                    if (ev_reg == EV_INTEGER) val_reg <= to_res(acc_reg);
                    else val_reg <= to_res(neg_reg ? (~sh_reg + 1'b1) : sh_reg);
                end
                ST_OUT: out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_event_kind   = ev_reg;
    assign m_echo_char    = echo_reg;
    assign m_result_value = val_reg;
    assign m_hundredths   = hund_reg;

    property p_busy_blocks;
        @(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready;
    endproperty
    a_busy_blocks: assert property (p_busy_blocks) else $error("ready while busy");

    property p_hund_range;
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hundredths <= 7'd99);
    endproperty
    a_hund_range: assert property (p_hund_range) else $error("hundredths range");

    property p_frac_only_quot;
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_kind != EV_QUOTIENT) |-> (m_hundredths == 7'd0);
    endproperty
    a_frac_only_quot: assert property (p_frac_only_quot) else $error("stray hundredths");

    property p_locked_after_result;
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_event_kind == EV_INTEGER || m_event_kind == EV_QUOTIENT
            || m_event_kind == EV_DIVZERO)) |-> (phase_reg == PH_LOCKED);
    endproperty
    a_locked_after_result: assert property (p_locked_after_result)
        else $error("result without lock");

endmodule
`default_nettype wire

FILE: test/keypad_four_function_calculator_checker.sv
// ----------------------------------------------------------------------------
// keypad_four_function_calculator_checker
// Watches the key and event channels, predicts each event from the keys
// accepted so far and compares every event field against the prediction.
// ----------------------------------------------------------------------------
module keypad_four_function_calculator_checker
    import kpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_key_code,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_event_kind,
    input  logic [7:0]  m_echo_char,
    input  logic [31:0] m_result_value,
    input  logic [6:0]  m_hundredths,
    output int          fail_count,
    output int          events_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  echo;
        logic [31:0] value;
        logic [6:0]  hund;
    } calc_event_t;

    calc_event_t event_queue[$];
    phase_t      calc_phase;
    logic [31:0] lhs, rhs;
    operation_t  calc_op;

    assign events_pending = event_queue.size();

    function automatic calc_event_t press_key(input logic [7:0] key);
        calc_event_t e;
        logic [31:0] qm, rm, ma, mb;
        logic [63:0] frac;
        e = '0;
        e.kind = EV_IGNORED;
        if (key == KEY_CLEAR) begin
            lhs = '0;
            rhs = '0;
            calc_op = OP_DIV;
            calc_phase = PH_FIRST;
            e.kind = EV_CLEARED;
        end else if (key >= KEY_ZERO && key <= KEY_NINE && calc_phase != PH_LOCKED) begin
            e.kind = EV_DIGIT;
            e.echo = key;
            if (calc_phase == PH_FIRST)
                lhs = lhs * 32'd10 + 32'(key - KEY_ZERO);
            else if (calc_phase == PH_SECOND)
                rhs = rhs * 32'd10 + 32'(key - KEY_ZERO);
        end else if (key >= KEY_OP_A && key <= KEY_OP_D && calc_phase == PH_FIRST) begin
            calc_op = operation_t'(2'(key - KEY_OP_A));
            calc_phase = PH_SECOND;
            e.kind = EV_OPERATOR;
            case (calc_op)
                OP_DIV: e.echo = SYM_DIV;
                OP_MUL: e.echo = SYM_MUL;
                OP_SUB: e.echo = SYM_SUB;
                default: e.echo = SYM_ADD;
            endcase
        end else if (key == KEY_EQUALS && calc_phase == PH_SECOND) begin
            case (calc_op)
                OP_ADD: begin e.kind = EV_INTEGER; e.value = lhs + rhs; end
                OP_SUB: begin e.kind = EV_INTEGER; e.value = lhs - rhs; end
                OP_MUL: begin e.kind = EV_INTEGER; e.value = lhs * rhs; end
                default: begin
                    if (rhs == 0) begin
                        e.kind = EV_DIVZERO;
                    end else begin
                        ma = lhs[31] ? -lhs : lhs;
                        mb = rhs[31] ? -rhs : rhs;
                        qm = ma / mb;
                        rm = ma % mb;
                        frac = (64'(rm) * 64'd100) / 64'(mb);
                        e.kind = EV_QUOTIENT;
                        e.value = (lhs[31] ^ rhs[31]) ? -qm : qm;
                        e.hund = 7'(frac);
                    end
                end
            endcase
            calc_phase = PH_LOCKED;
        end
        return e;
    endfunction

    always @(posedge aclk) begin
        calc_event_t got, want;
        if (!aresetn) begin
            calc_phase = PH_FIRST;
            lhs = '0;
            rhs = '0;
            calc_op = OP_DIV;
            event_queue.delete();
            fail_count = 0;
        end else begin
            if (s_valid && s_ready)
                event_queue.push_back(press_key(s_key_code));
            if (m_valid && m_ready) begin
                got = {m_event_kind, m_echo_char, m_result_value, m_hundredths};
                if (event_queue.size() == 0) begin
                    $display("%0t: unexpected event, actual %h", $realtime, got);
                    fail_count++;
                end else begin
                    want = event_queue.pop_front();
                    if (got.kind !== want.kind)
                        $display("%0t: event_kind expected %0d actual %0d",
                                 $realtime, want.kind, got.kind);
                    if (got.echo !== want.echo)
                        $display("%0t: echo_char expected %h actual %h",
                                 $realtime, want.echo, got.echo);
                    if (got.value !== want.value)
                        $display("%0t: result_value expected %0d actual %0d",
                                 $realtime, $signed(want.value), $signed(got.value));
                    if (got.hund !== want.hund)
                        $display("%0t: hundredths expected %0d actual %0d",
                                 $realtime, want.hund, got.hund);
                    if (got !== want)
                        fail_count++;
                end
            end
        end
    end
endmodule

FILE: test/keypad_four_function_calculator_test.sv
// ----------------------------------------------------------------------------
// keypad_four_function_calculator_test
// Drives key sequences (directed corners, then random calculations and noise)
// through the calculator under several idle and stall patterns.
// ----------------------------------------------------------------------------
module keypad_four_function_calculator_test;
    import kpc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_key_code = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_event_kind;
    logic [7:0]  m_echo_char;
    logic signed [31:0] m_result_value;
    logic [6:0]  m_hundredths;
    int          fail_count, events_pending;
    int          send_idle_pct = 0, recv_stall_pct = 0;
    bit          hold_off = 1'b0;
    int          quiet_cycles = 0;

    always #10 aclk = ~aclk;

    keypad_four_function_calculator dut (.*);

    keypad_four_function_calculator_checker checker_i (.*);

    always @(posedge aclk) begin
        if (hold_off)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("keypad_four_function_calculator_test NOT OK");
            $finish;
        end
    end

    // Valid stays up after a transfer only when the next key follows at once.
    task automatic send_key(input logic [7:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_key_code <= key;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_number(input logic [31:0] n);
        string s;
        s = $sformatf("%0d", n);
        foreach (s[i]) send_key(s[i]);
    endtask

    // Mostly well-formed "a op b #" sequences, with noise and broken ones mixed in.
    task automatic send_random_sequence();
        logic [31:0] a, b;
        int shape;
        shape = $urandom_range(9);
        a = (shape < 2) ? $urandom() : $urandom_range(999);
        b = (shape == 3) ? 0 : ((shape < 2) ? $urandom() : $urandom_range(99));
        if (shape == 9) begin
            repeat ($urandom_range(1, 6)) send_key(8'($urandom()));
            return;
        end
        send_key(KEY_CLEAR);
        send_number(a);
        send_key(KEY_OP_A + 8'($urandom_range(3)));
        if (shape == 8) send_key(KEY_OP_A + 8'($urandom_range(3)));
        send_number(b);
        if (shape == 7) send_key(8'($urandom()));
        send_key(KEY_EQUALS);
        if (shape >= 6) send_key(KEY_ZERO + 8'($urandom_range(9)));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (events_pending != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: digits and ignored keys, each operator, corners.
        send_key(8'h00);
        send_key(8'hFF);
        send_key(KEY_EQUALS);
        send_number(32'd2147483647);
        send_key(KEY_OP_A);
        send_number(32'd0);
        send_key(KEY_EQUALS);
        send_key(KEY_NINE);
        send_key(KEY_CLEAR);
        send_number(32'd4294967295);
        send_key(KEY_OP_A);
        send_key(KEY_ZERO + 8'd7);
        send_key(KEY_EQUALS);
        send_key(KEY_CLEAR);
        send_key(KEY_OP_A + 8'd1);
        send_number(32'd99999);
        send_key(KEY_EQUALS);
        send_key(KEY_CLEAR);
        send_key(KEY_OP_D);
        send_key(KEY_EQUALS);
        send_key(KEY_CLEAR);
        send_key(KEY_OP_A + 8'd2);
        send_key(KEY_NINE);
        send_key(KEY_EQUALS);
        drain();

        // most negative divided by minus one
        send_key(KEY_CLEAR);
        send_number(32'd2147483648);
        send_key(KEY_OP_A);
        send_number(32'd4294967295);
        send_key(KEY_EQUALS);
        drain();

        // Long receiver hold-off while keys keep coming.
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            repeat (20) send_random_sequence();
        join
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 55; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 55; end
                3: begin send_idle_pct = 34; recv_stall_pct = 34; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            repeat (29) send_random_sequence();
        end

        drain();
        repeat (100) @(posedge aclk);
        if (fail_count == 0)
            $display("keypad_four_function_calculator_test OK");
        else
            $display("keypad_four_function_calculator_test NOT OK");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/kpc_pkg.sv
rtl/keypad_four_function_calculator.sv
test/keypad_four_function_calculator_checker.sv
test/keypad_four_function_calculator_test.sv
